FILE: design/gnms_pkg.sv
// shared types, constants and helpers for gradient non-maxima suppression
package gnms_pkg;

   localparam int MAX_WIDTH_DEF = 1024;
   localparam int MAG_W         = 16;
   localparam int FW_W          = 11;
   localparam int FH_W          = 16;
   localparam int CSR_DATA_W    = 16;
   localparam int MIN_DIM       = 3;
   localparam int QUEUE_DEPTH   = 4;

   localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 11'd640;
   localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 16'd480;

   localparam logic CSR_FRAME_WIDTH  = 1'b0;
   localparam logic CSR_FRAME_HEIGHT = 1'b1;

   localparam logic ACT_PIXEL = 1'b0;
   localparam logic ACT_FLUSH = 1'b1;

   typedef enum logic [1:0] {
      DIR_DIAG  = 2'd0,
      DIR_VERT  = 2'd1,
      DIR_ANTI  = 2'd2,
      DIR_HORIZ = 2'd3
   } dir_type;

   typedef struct packed {
      logic store;
      logic emit;
      logic interior;
      logic last;
   } ctrl_type;

   // ((angle >> 4) + 15) % 8 / 2
   function automatic dir_type angle_to_dir(input logic [7:0] angle);
      logic [2:0] sector;
      sector = angle[6:4] - 3'd1;
      return dir_type'(sector[2:1]);
   endfunction

endpackage

FILE: design/gnms_ram.sv
// generic single-write, single-read RAM with registered read-first output
module gnms_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/gnms_front.sv
// front end: frame position tracking, item classification and csr registers
module gnms_front #(
   parameter int MAX_WIDTH = gnms_pkg::MAX_WIDTH_DEF,
   localparam int COL_W = $clog2(MAX_WIDTH),
   localparam int WID_W = $clog2(MAX_WIDTH + 1)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [23:0]                 req_tdata,
   input  logic [0:0]                  req_tuser,
   input  logic                        csr_we,
   input  logic [0:0]                  csr_addr,
   input  logic [gnms_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                        q_full,
   output logic                        q_push,
   output gnms_pkg::ctrl_type          q_ctrl,
   output logic [COL_W-1:0]            q_col,
   output gnms_pkg::dir_type           q_dir,
   output logic [gnms_pkg::MAG_W-1:0]  q_mag
);

   import gnms_pkg::*;

   logic [FW_W-1:0]  frame_width_ff, frame_width_in;
   logic [FH_W-1:0]  frame_height_ff, frame_height_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [FH_W-1:0]  row_ff, row_in;
   logic             done_ff, done_in;
   logic             wrap_ff, wrap_in;

   logic [WID_W-1:0] eff_w;
   logic [FH_W-1:0]  eff_h;
   logic             last_col;
   logic             last_row;
   logic             accept;

   always_comb begin
      if (32'(frame_width_ff) > MAX_WIDTH) begin
         eff_w = WID_W'(MAX_WIDTH);
      end else if (frame_width_ff < FW_W'(MIN_DIM)) begin
         eff_w = WID_W'(MIN_DIM);
      end else begin
         eff_w = WID_W'(frame_width_ff);
      end
      if (frame_height_ff < FH_W'(MIN_DIM)) begin
         eff_h = FH_W'(MIN_DIM);
      end else begin
         eff_h = frame_height_ff;
      end
   end

   assign last_col   = (WID_W'(col_ff) == (eff_w - WID_W'(1)));
   assign last_row   = (row_ff == (eff_h - FH_W'(1)));
   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;

   assign q_col = col_ff;
   assign q_mag = req_tdata[MAG_W-1:0];
   assign q_dir = angle_to_dir(req_tdata[23:16]);

   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      col_in          = col_ff;
      row_in          = row_ff;
      done_in         = done_ff;
      wrap_in         = wrap_ff;
      q_push          = 1'b0;
      q_ctrl          = '0;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_FRAME_WIDTH:  frame_width_in  = csr_wdata[FW_W-1:0];
            CSR_FRAME_HEIGHT: frame_height_in = csr_wdata[FH_W-1:0];
            default:          frame_width_in  = frame_width_ff;
         endcase
         col_in  = '0;
         row_in  = '0;
         done_in = 1'b0;
         wrap_in = 1'b0;
      end else if (accept) begin
         priority if (req_tuser[0] == ACT_PIXEL && !done_ff) begin
            q_push         = 1'b1;
            q_ctrl.store   = 1'b1;
            q_ctrl.emit    = (row_ff >= FH_W'(2)) || (row_ff == FH_W'(1) && col_ff != '0);
            q_ctrl.interior = (row_ff >= FH_W'(2)) && (col_ff >= COL_W'(2));
            q_ctrl.last    = 1'b0;
            if (last_col) begin
               col_in = '0;
               if (last_row) begin
                  row_in  = '0;
                  done_in = 1'b1;
               end else begin
                  row_in = row_ff + FH_W'(1);
               end
            end else begin
               col_in = col_ff + COL_W'(1);
            end
         end else if (req_tuser[0] == ACT_FLUSH && done_ff) begin
            q_push          = 1'b1;
            q_ctrl.store    = 1'b0;
            q_ctrl.emit     = 1'b1;
            q_ctrl.interior = 1'b0;
            q_ctrl.last     = wrap_ff;
            if (wrap_ff) begin
               col_in  = '0;
               done_in = 1'b0;
               wrap_in = 1'b0;
            end else if (last_col) begin
               col_in  = '0;
               wrap_in = 1'b1;
            end else begin
               col_in = col_ff + COL_W'(1);
            end
         end else begin
            q_push = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RST;
         frame_height_ff <= FRAME_HEIGHT_RST;
         col_ff          <= '0;
         row_ff          <= '0;
         done_ff         <= 1'b0;
         wrap_ff         <= 1'b0;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
         col_ff          <= col_in;
         row_ff          <= row_in;
         done_ff         <= done_in;
         wrap_ff         <= wrap_in;
      end
   end

endmodule

FILE: design/gnms_fifo.sv
// small register queue between front and back ends
module gnms_fifo #(
   parameter int WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             pop_valid,
   output logic [WIDTH-1:0] pop_data
);

   import gnms_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data  = entry_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(do_push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: design/gnms_back.sv
// back end: line buffers, 3x3 window and suppression decision
module gnms_back #(
   parameter int MAX_WIDTH = gnms_pkg::MAX_WIDTH_DEF,
   localparam int COL_W = $clog2(MAX_WIDTH)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       q_valid,
   output logic                       q_pop,
   input  gnms_pkg::ctrl_type         q_ctrl,
   input  logic [COL_W-1:0]           q_col,
   input  gnms_pkg::dir_type          q_dir,
   input  logic [gnms_pkg::MAG_W-1:0] q_mag,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [15:0]                rsp_tdata,
   output logic [0:0]                 rsp_tuser,
   output logic                       rsp_tlast
);

   import gnms_pkg::*;

   localparam int LINE_A_W = MAG_W + 2;

   logic             s1_valid_ff, s1_valid_in;
   ctrl_type         s1_ctrl_ff;
   logic [COL_W-1:0] s1_col_ff;
   logic [MAG_W-1:0] s1_mag_ff;

   logic [LINE_A_W-1:0] a_rd;
   logic [MAG_W-1:0]    b_rd;

   logic [MAG_W-1:0] p1_top_ff, p1_mid_ff, p1_bot_ff;
   logic [MAG_W-1:0] p2_top_ff, p2_mid_ff, p2_bot_ff;
   dir_type          p1_dir_ff;

   logic [MAG_W-1:0] cur_top, cur_mid, cur_bot;
   dir_type          cur_dir;
   logic [MAG_W-1:0] n1, n2;
   logic             supp;

   logic             out_valid_ff, out_valid_in;
   logic [MAG_W-1:0] out_mag_ff;
   logic             out_supp_ff;
   logic             out_last_ff;

   logic out_free;
   logic s1_adv;

   assign out_free = !out_valid_ff || rsp_tready;
   assign s1_adv   = s1_valid_ff && out_free;
   assign q_pop    = q_valid && (!s1_valid_ff || s1_adv);

   // row r-1 magnitude and direction
   gnms_ram #(
      .WIDTH (LINE_A_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_a (
      .clock   (clock),
      .wr_en   (q_pop && q_ctrl.store),
      .wr_addr (q_col),
      .wr_data ({q_dir, q_mag}),
      .rd_en   (q_pop),
      .rd_addr (q_col),
      .rd_data (a_rd)
   );

   // row r-2 magnitude
   gnms_ram #(
      .WIDTH (MAG_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_b (
      .clock   (clock),
      .wr_en   (s1_adv && s1_ctrl_ff.store),
      .wr_addr (s1_col_ff),
      .wr_data (a_rd[MAG_W-1:0]),
      .rd_en   (q_pop),
      .rd_addr (q_col),
      .rd_data (b_rd)
   );

   assign cur_top = b_rd;
   assign cur_mid = a_rd[MAG_W-1:0];
   assign cur_dir = dir_type'(a_rd[LINE_A_W-1:MAG_W]);
   assign cur_bot = s1_mag_ff;

   always_comb begin
      unique case (p1_dir_ff)
         DIR_DIAG: begin
            n1 = p2_top_ff;
            n2 = cur_bot;
         end
         DIR_VERT: begin
            n1 = p1_top_ff;
            n2 = p1_bot_ff;
         end
         DIR_ANTI: begin
            n1 = cur_top;
            n2 = p2_bot_ff;
         end
         default: begin
            n1 = cur_mid;
            n2 = p2_mid_ff;
         end
      endcase
      supp = s1_ctrl_ff.interior && ((n1 > p1_mid_ff) || (n2 > p1_mid_ff));
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (q_pop) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (s1_adv && s1_ctrl_ff.emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         s1_ctrl_ff <= q_ctrl;
         s1_col_ff  <= q_col;
         s1_mag_ff  <= q_mag;
      end
      if (s1_adv) begin
         p2_top_ff <= p1_top_ff;
         p2_mid_ff <= p1_mid_ff;
         p2_bot_ff <= p1_bot_ff;
         p1_top_ff <= cur_top;
         p1_mid_ff <= cur_mid;
         p1_bot_ff <= cur_bot;
         p1_dir_ff <= cur_dir;
      end
      if (s1_adv && s1_ctrl_ff.emit) begin
         out_mag_ff  <= supp ? '0 : p1_mid_ff;
         out_supp_ff <= supp;
         out_last_ff <= s1_ctrl_ff.last;
      end
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_tvalid   = out_valid_ff;
   assign rsp_tdata    = out_mag_ff;
   assign rsp_tuser[0] = out_supp_ff;
   assign rsp_tlast    = out_last_ff;

endmodule

FILE: design/gradient_non_maxima_suppression_top.sv
// top level of the 3x3 gradient non-maxima suppression stream block
// throughput: one item per clock unless stalled; a registered result follows the transfer of
// the item that completes its window (the lower-right neighbour), one row plus one pixel later
// in the stream; the line buffers have one read and one write port each, at one pixel a clock
// w+1 flush transfers after the last pixel drain the final row of a frame
// reset: frame counters cleared, frame_width 640, frame_height 480; line buffers keep contents
module gradient_non_maxima_suppression_top #(
   parameter int MAX_WIDTH = gnms_pkg::MAX_WIDTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [23:0]                     req_tdata,  // magnitude[15:0], angle[23:16]
   input  logic [0:0]                      req_tuser,  // action[0]
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [15:0]                     rsp_tdata,  // magnitude_out[15:0]
   output logic [0:0]                      rsp_tuser,  // suppressed[0]
   output logic                            rsp_tlast,
   input  logic                            csr_we,
   input  logic [0:0]                      csr_addr,
   input  logic [gnms_pkg::CSR_DATA_W-1:0] csr_wdata
);

   import gnms_pkg::*;

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int CTRL_W = $bits(ctrl_type);
   localparam int Q_W    = COL_W + 2 + MAG_W + CTRL_W;

   logic             push;
   ctrl_type         f_ctrl;
   logic [COL_W-1:0] f_col;
   dir_type          f_dir;
   logic [MAG_W-1:0] f_mag;
   logic             q_full;
   logic             q_valid;
   logic             q_pop;
   logic [Q_W-1:0]   q_data;

   gnms_front #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .q_full     (q_full),
      .q_push     (push),
      .q_ctrl     (f_ctrl),
      .q_col      (f_col),
      .q_dir      (f_dir),
      .q_mag      (f_mag)
   );

   gnms_fifo #(
      .WIDTH (Q_W)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({f_col, f_dir, f_mag, f_ctrl}),
      .full      (q_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_data  (q_data)
   );

   gnms_back #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_pop      (q_pop),
      .q_ctrl     (ctrl_type'(q_data[CTRL_W-1:0])),
      .q_col      (q_data[Q_W-1 -: COL_W]),
      .q_dir      (dir_type'(q_data[CTRL_W+MAG_W+1 -: 2])),
      .q_mag      (q_data[CTRL_W+MAG_W-1 -: MAG_W]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
